FILE: rtl/ghbe_pkg.sv
// ----------------------------------------------------------------------------
// ghbe_pkg
// Shared widths, codes, controller states and the control/status bundles of
// the grant history backlog estimator.
// ----------------------------------------------------------------------------
package ghbe_pkg;

   localparam int HISTORY_DEPTH_DEF = 64;

   localparam int TIME_W  = 48;
   localparam int OCC_W   = 24;
   localparam int WORDS_W = 16;
   localparam int RTT_W   = 32;
   localparam int SLOT_W  = 32;
   localparam int OFS_W   = RTT_W + 1;

   // ring entry: {report flag, size, time}
   localparam int ENTRY_W = TIME_W + WORDS_W + 1;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 32;
   localparam int CMD_W      = 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_REPORT = 2'd0;
   localparam cmd_type CMD_GRANT  = 2'd1;
   localparam cmd_type CMD_QUERY  = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_RTT    = 2'd0;
   localparam csr_idx_type CSR_SLOT   = 2'd1;
   localparam csr_idx_type CSR_WINDOW = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRUNE_RD,
      ST_PRUNE_CHK,
      ST_APPEND,
      ST_Q_WALK,
      ST_Q_FINISH
   } state_type;

   typedef struct packed {
      logic load_report;
      logic load_grant;
      logic load_query;
      logic prune_rd;
      logic prune_drop;
      logic append;
      logic q_walk;
      logic q_finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic prune_go;   // pruning enabled and ring not empty
      logic prune_hit;  // oldest grant is older than the window
      logic walk_done;
      logic rsp_busy;   // output register holds an item not yet taken
   } dp_stat_type;

endpackage

FILE: rtl/grant_history_backlog_estimator_unit.sv
// ----------------------------------------------------------------------------
// grant_history_backlog_estimator_unit
// Backlog estimator over the last occupancy report and a ring of grants.
// ----------------------------------------------------------------------------
// Report item: taken in idle, the block stays idle. Grant item: the oldest
// grant is read and checked, and dropped while it is older than the window,
// with one ring read per check; then the new grant is appended. Query: walk
// reads go newest to oldest (up to HISTORY_DEPTH), then the result register
// loads once it is free. One item in work at a time; the result register lets
// the next item in. Sync reset clears report, pointers, flags, registers.
module grant_history_backlog_estimator_unit #(
   parameter int HISTORY_DEPTH = ghbe_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // event_time[47:0], buffer_occupancy[71:48], grant_words[87:72],
   // grant_has_report[88], zero pad
   input  logic [ghbe_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd[1:0]
   input  logic [ghbe_pkg::CMD_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // remaining_words[23:0], history_overflowed[24], zero pad
   output logic [ghbe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [ghbe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ghbe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import ghbe_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   ghbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (cmd_type'(req_tuser)),
      .stat       (stat),
      .cmd        (cmd)
   );

   ghbe_dpath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_idx_type'(csr_index)),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/ghbe_ram.sv
// ----------------------------------------------------------------------------
// ghbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ghbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ghbe_ctrl.sv
// ----------------------------------------------------------------------------
// ghbe_ctrl
// Controller: takes items, sequences grant pruning/append and the query walk.
// ----------------------------------------------------------------------------
module ghbe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ghbe_pkg::cmd_type      req_tuser,
   input  ghbe_pkg::dp_stat_type  stat,
   output ghbe_pkg::ctrl_cmd_type cmd
);

   import ghbe_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_tuser)
                  CMD_REPORT: cmd.load_report = 1'b1;
                  CMD_GRANT: begin
                     cmd.load_grant = 1'b1;
                     state_in       = ST_PRUNE_RD;
                  end
                  CMD_QUERY: begin
                     cmd.load_query = 1'b1;
                     state_in       = ST_Q_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_PRUNE_RD: begin
            if (stat.prune_go) begin
               cmd.prune_rd = 1'b1;
               state_in     = ST_PRUNE_CHK;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_PRUNE_CHK: begin
            if (stat.prune_hit) begin
               cmd.prune_drop = 1'b1;
               state_in       = ST_PRUNE_RD;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_Q_WALK: begin
            cmd.q_walk = 1'b1;
            if (stat.walk_done) begin
               state_in = ST_Q_FINISH;
            end
         end
         ST_Q_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.q_finish = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/ghbe_dpath.sv
// ----------------------------------------------------------------------------
// ghbe_dpath
// Datapath: registers, report state, grant ring, query accumulator and the
// result register.
// ----------------------------------------------------------------------------
module ghbe_dpath #(
   parameter int HISTORY_DEPTH = ghbe_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ghbe_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                csr_wr_en,
   input  ghbe_pkg::csr_idx_type               csr_index,
   input  logic [ghbe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  ghbe_pkg::ctrl_cmd_type              cmd,
   output ghbe_pkg::dp_stat_type               stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ghbe_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   import ghbe_pkg::*;

   localparam int IDX_W  = $clog2(HISTORY_DEPTH);
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int ASUM_W = CNT_W + 1;
   localparam int SUM_W  = WORDS_W + CNT_W + 1;
   localparam int DIFF_W = ((SUM_W > OCC_W + 1) ? SUM_W : OCC_W + 1) + 1;

   // request fields
   logic [TIME_W-1:0]  in_time;
   logic [OCC_W-1:0]   in_occ;
   logic [WORDS_W-1:0] in_words;
   logic               in_flag;

   assign in_time  = req_tdata[TIME_W-1:0];
   assign in_occ   = req_tdata[TIME_W+OCC_W-1:TIME_W];
   assign in_words = req_tdata[TIME_W+OCC_W+WORDS_W-1:TIME_W+OCC_W];
   assign in_flag  = req_tdata[TIME_W+OCC_W+WORDS_W];

   // configuration
   logic [RTT_W-1:0]  rtt_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [TIME_W-1:0] window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rtt_ff    <= '0;
         slot_ff   <= '0;
         window_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RTT:    rtt_ff    <= csr_wdata[RTT_W-1:0];
            CSR_SLOT:   slot_ff   <= csr_wdata[SLOT_W-1:0];
            CSR_WINDOW: window_ff <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // state registers
   logic               present_ff, present_in;
   logic [OCC_W-1:0]   rep_words_ff, rep_words_in;
   logic [TIME_W-1:0]  rep_time_ff, rep_time_in;
   logic [IDX_W-1:0]   oldest_ff, oldest_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;

   // grant scratch
   logic [TIME_W-1:0]  g_time_ff, g_time_in;
   logic [WORDS_W-1:0] g_words_ff, g_words_in;
   logic               g_flag_ff, g_flag_in;
   logic [TIME_W-1:0]  thr_ff, thr_in;
   logic               prune_en_ff, prune_en_in;

   // query scratch
   logic [OFS_W-1:0]   offset_ff, offset_in;
   logic [CNT_W-1:0]   walk_left_ff, walk_left_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OCC_W-1:0]   rsp_words_ff, rsp_words_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   // ring storage
   logic               ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
   logic [TIME_W-1:0]  e_time;
   logic [WORDS_W-1:0] e_size;
   logic               e_flag;

   ghbe_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign e_time = ram_rd_data[TIME_W-1:0];
   assign e_size = ram_rd_data[TIME_W+WORDS_W-1:TIME_W];
   assign e_flag = ram_rd_data[ENTRY_W-1];

   // ring index arithmetic, sums stay below twice the depth
   logic [ASUM_W-1:0] walk_sum, tail_sum;
   logic [IDX_W-1:0]  walk_addr, tail_addr, oldest_inc;
   logic              full;

   assign walk_sum  = ASUM_W'(oldest_ff) + ASUM_W'(walk_left_ff) - ASUM_W'(1);
   assign walk_addr = (walk_sum >= ASUM_W'(HISTORY_DEPTH))
                      ? IDX_W'(walk_sum - ASUM_W'(HISTORY_DEPTH)) : IDX_W'(walk_sum);
   assign tail_sum  = ASUM_W'(oldest_ff) + ASUM_W'(count_ff);
   assign tail_addr = (tail_sum >= ASUM_W'(HISTORY_DEPTH))
                      ? IDX_W'(tail_sum - ASUM_W'(HISTORY_DEPTH)) : IDX_W'(tail_sum);
   assign oldest_inc = (oldest_ff == IDX_W'(HISTORY_DEPTH - 1))
                       ? '0 : oldest_ff + IDX_W'(1);
   assign full = (count_ff == CNT_W'(HISTORY_DEPTH));

   // query walk
   logic hit, stop, issue;
   assign hit   = ({1'b0, e_time} + (TIME_W+1)'(offset_ff)) > {1'b0, rep_time_ff};
   assign stop  = rd_pend_ff && !hit;
   assign issue = (walk_left_ff != '0) && !stop;

   // final estimate with clamping
   logic [DIFF_W-1:0] diff;
   logic [OCC_W-1:0]  clamped;
   assign diff = {{(DIFF_W-OCC_W){1'b0}}, rep_words_ff}
               - {{(DIFF_W-SUM_W){sum_ff[SUM_W-1]}}, sum_ff};
   always_comb begin
      if (diff[DIFF_W-1]) begin
         clamped = '0;
      end else if (diff[DIFF_W-2:OCC_W] != '0) begin
         clamped = '1;
      end else begin
         clamped = diff[OCC_W-1:0];
      end
   end

   always_comb begin
      present_in   = present_ff;
      rep_words_in = rep_words_ff;
      rep_time_in  = rep_time_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      g_time_in    = g_time_ff;
      g_words_in   = g_words_ff;
      g_flag_in    = g_flag_ff;
      thr_in       = thr_ff;
      prune_en_in  = prune_en_ff;
      offset_in    = offset_ff;
      walk_left_in = walk_left_ff;
      rd_pend_in   = rd_pend_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_words_in = rsp_words_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = tail_addr;
      ram_wr_data  = {g_flag_ff, g_words_ff, g_time_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = oldest_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load_report) begin
         present_in   = 1'b1;
         rep_words_in = in_occ;
         rep_time_in  = in_time;
      end

      if (cmd.load_grant) begin
         g_time_in   = in_time;
         g_words_in  = in_words;
         g_flag_in   = in_flag;
         prune_en_in = in_time > window_ff;
         thr_in      = in_time - window_ff;
      end

      if (cmd.prune_rd) begin
         ram_rd_en = 1'b1;
      end

      if (cmd.prune_drop) begin
         oldest_in = oldest_inc;
         count_in  = count_ff - CNT_W'(1);
      end

      if (cmd.append) begin
         ram_wr_en = 1'b1;
         if (full) begin
            // ring full: oldest slot is overwritten by the new grant
            ram_wr_addr = oldest_ff;
            oldest_in   = oldest_inc;
            ovf_in      = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (cmd.load_query) begin
         offset_in    = OFS_W'(rtt_ff) + OFS_W'(slot_ff >> 1);
         walk_left_in = present_ff ? count_ff : '0;
         rd_pend_in   = 1'b0;
         sum_in       = '0;
      end

      if (cmd.q_walk) begin
         ram_rd_addr = walk_addr;
         ram_rd_en   = issue;
         rd_pend_in  = issue;
         if (issue) begin
            walk_left_in = walk_left_ff - CNT_W'(1);
         end
         if (rd_pend_ff && hit) begin
            sum_in = sum_ff + SUM_W'(e_size) - SUM_W'(e_flag);
         end
      end

      if (cmd.q_finish) begin
         rsp_valid_in = 1'b1;
         rsp_words_in = present_ff ? clamped : '0;
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= 1'b0;
         rep_words_ff <= '0;
         rep_time_ff  <= '0;
         oldest_ff    <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         present_ff   <= present_in;
         rep_words_ff <= rep_words_in;
         rep_time_ff  <= rep_time_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      g_time_ff    <= g_time_in;
      g_words_ff   <= g_words_in;
      g_flag_ff    <= g_flag_in;
      thr_ff       <= thr_in;
      prune_en_ff  <= prune_en_in;
      offset_ff    <= offset_in;
      walk_left_ff <= walk_left_in;
      sum_ff       <= sum_in;
      rsp_words_ff <= rsp_words_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign stat.prune_go  = prune_en_ff && (count_ff != '0);
   assign stat.prune_hit = e_time < thr_ff;
   assign stat.walk_done = stop || ((walk_left_ff == '0) && !rd_pend_ff);
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-OCC_W-1){1'b0}}, rsp_ovf_ff, rsp_words_ff};

endmodule

FILE: tb/grant_history_backlog_estimator_unit_tb.sv
// ----------------------------------------------------------------------------
// grant_history_backlog_estimator_unit_tb
// Self-checking bench for the backlog estimator. Report, grant and query items
// go in on the req stream. A behavioral tracker keeps its own report, grant
// ring and registers and predicts every estimate. The rsp stream is checked
// in order against those predictions. Both sides idle at random. One phase
// holds the output off long enough to back up the input. The registers are
// swept through zero, small, mid-range and all-ones settings.
// ----------------------------------------------------------------------------
module grant_history_backlog_estimator_unit_tb;
   import ghbe_pkg::*;

   localparam int DEPTH         = HISTORY_DEPTH_DEF;
   localparam int CYCLE_LIMIT   = 1000000;
   // a grant may prune the whole ring, one read and one check per entry
   localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
   localparam int IDLE_PCT      = 21;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam cmd_type CMD_UNDEFINED = 2'd3;

   typedef struct packed {
      logic [OCC_W-1:0] remaining_words;
      logic             history_overflowed;
   } estimate_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // event_time[47:0], buffer_occupancy[71:48], grant_words[87:72],
   // grant_has_report[88], zero pad
   logic [REQ_DATA_W-1:0] req_tdata;
   // cmd[1:0]
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // remaining_words[23:0], history_overflowed[24], zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // tracker copy of the registers and the block state
   logic [RTT_W-1:0]   trk_rtt;
   logic [SLOT_W-1:0]  trk_slot;
   logic [TIME_W-1:0]  trk_window;
   logic               trk_have_report;
   logic [OCC_W-1:0]   trk_occ;
   logic [TIME_W-1:0]  trk_report_time;
   logic [TIME_W-1:0]  ring_time  [DEPTH];
   logic [WORDS_W-1:0] ring_words [DEPTH];
   logic               ring_flag  [DEPTH];
   int                 ring_head;
   int                 ring_count;
   logic               trk_overflow;

   estimate_type       pending_estimates[$];
   int                 errors;
   int                 items_sent;
   int                 grants_sent;
   int                 reports_sent;
   int                 estimates_checked;
   int                 cycle_count;
   int                 stall_request = 0;
   bit                 quiet_mode = 1'b0;
   logic [TIME_W-1:0]  now;

   grant_history_backlog_estimator_unit #(
      .HISTORY_DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timeout after %0d cycles, %0d estimates pending", cycle_count,
             pending_estimates.size());
      $display("TB_ERROR");
      $finish;
   end

   // receiver: random back-pressure, plus long hold-offs on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      estimate_type got;
      estimate_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.remaining_words    = rsp_tdata[OCC_W-1:0];
         got.history_overflowed = rsp_tdata[OCC_W];
         if (pending_estimates.size() == 0) begin
            $error("unexpected result: remaining_words %0d, history_overflowed %0d",
                   got.remaining_words, got.history_overflowed);
            errors++;
         end else begin
            want = pending_estimates[0];
            pending_estimates.delete(0);
            if (got.remaining_words !== want.remaining_words) begin
               $error("remaining_words: expected %0d, actual %0d",
                      want.remaining_words, got.remaining_words);
               errors++;
            end
            if (got.history_overflowed !== want.history_overflowed) begin
               $error("history_overflowed: expected %0d, actual %0d",
                      want.history_overflowed, got.history_overflowed);
               errors++;
            end
            estimates_checked++;
         end
      end
   end

   function automatic logic [TIME_W-1:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // newest to oldest, while the grant lands after the report
   function automatic estimate_type estimate_backlog();
      estimate_type res;
      longint       assigned;
      longint       remain;
      logic [63:0]  offset;
      int           idx;
      res.history_overflowed = trk_overflow;
      assigned = 0;
      offset   = 64'(trk_rtt) + 64'(trk_slot >> 1);
      if (!trk_have_report) begin
         res.remaining_words = '0;
      end else if (ring_count == 0) begin
         res.remaining_words = trk_occ;
      end else begin
         for (int k = ring_count; k > 0; k--) begin
            idx = (ring_head + k - 1) % DEPTH;
            if (64'(ring_time[idx]) + offset <= 64'(trk_report_time))
               break;
            assigned += longint'(ring_words[idx]);
            if (ring_flag[idx])
               assigned -= 1;
         end
         remain = longint'(trk_occ) - assigned;
         if (remain < 0)
            remain = 0;
         if (remain > 16777215)
            remain = 16777215;
         res.remaining_words = remain[OCC_W-1:0];
      end
      return res;
   endfunction

   task automatic track_item(cmd_type cmd, logic [TIME_W-1:0] t, logic [OCC_W-1:0] occ,
                             logic [WORDS_W-1:0] words, logic flag);
      int slot;
      case (cmd)
         CMD_REPORT: begin
            trk_have_report = 1'b1;
            trk_occ         = occ;
            trk_report_time = t;
            reports_sent++;
         end
         CMD_GRANT: begin
            if (t > trk_window) begin
               while (ring_count > 0 && ring_time[ring_head] < t - trk_window) begin
                  ring_head = (ring_head + 1) % DEPTH;
                  ring_count--;
               end
            end
            if (ring_count >= DEPTH) begin
               ring_head    = (ring_head + 1) % DEPTH;
               ring_count--;
               trk_overflow = 1'b1;
            end
            slot             = (ring_head + ring_count) % DEPTH;
            ring_time[slot]  = t;
            ring_words[slot] = words;
            ring_flag[slot]  = flag;
            ring_count++;
            grants_sent++;
         end
         CMD_QUERY: pending_estimates = {pending_estimates, estimate_backlog()};
         default: ;
      endcase
   endtask

   task automatic send_item(cmd_type cmd, logic [TIME_W-1:0] t, logic [OCC_W-1:0] occ,
                            logic [WORDS_W-1:0] words, logic flag);
      while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom, $urandom};
         req_tuser  <= CMD_W'($urandom_range(3));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, flag, words, occ, t};
      do @(posedge clock); while (req_tready !== 1'b1);
      track_item(cmd, t, occ, words, flag);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_estimates.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_RTT:    trk_rtt    = value[RTT_W-1:0];
         CSR_SLOT:   trk_slot   = value[SLOT_W-1:0];
         CSR_WINDOW: trk_window = value[TIME_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [RTT_W-1:0] rtt, logic [SLOT_W-1:0] slot,
                             logic [TIME_W-1:0] window);
      wait_idle();
      write_reg(CSR_RTT, CSR_DATA_W'(rtt));
      write_reg(CSR_SLOT, CSR_DATA_W'(slot));
      write_reg(CSR_WINDOW, window);
   endtask

   task automatic send_random_grant(int step_max);
      logic [WORDS_W-1:0] words;
      now   = now + TIME_W'($urandom_range(0, step_max));
      words = ($urandom_range(99) < 15) ? WORDS_W'($urandom)
                                        : WORDS_W'($urandom_range(0, 600));
      send_item(CMD_GRANT, now, OCC_W'($urandom), words, 1'($urandom_range(1)));
   endtask

   task automatic test_directed_cases();
      send_item(CMD_QUERY, '0, '0, '0, 1'b0);                  // no report yet
      send_item(CMD_REPORT, 48'd100, 24'hFFFFFF, 16'hFFFF, 1'b1);
      send_item(CMD_QUERY, TIME_MAX, '0, '0, 1'b0);            // no grants: occupancy
      // zero-size grant with report word pushes the estimate past the top
      send_item(CMD_GRANT, 48'd200, 24'hFFFFFF, 16'd0, 1'b1);
      send_item(CMD_QUERY, '0, 24'hFFFFFF, 16'hFFFF, 1'b1);
      send_item(CMD_REPORT, 48'd300, 24'd10, '0, 1'b0);
      send_item(CMD_QUERY, '0, '0, '0, 1'b0);                  // walk stops at once
      send_item(CMD_GRANT, 48'd400, '0, 16'hFFFF, 1'b0);       // grant exceeds backlog
      send_item(CMD_QUERY, '0, '0, '0, 1'b0);
      send_item(CMD_UNDEFINED, TIME_MAX, 24'hFFFFFF, 16'hFFFF, 1'b1);
      send_item(CMD_QUERY, '0, '0, '0, 1'b0);
      send_item(CMD_REPORT, TIME_MAX, 24'd1234, 16'hFFFF, 1'b1);
      send_item(CMD_GRANT, TIME_MAX, 24'hFFFFFF, 16'd77, 1'b1); // prunes all older
      send_item(CMD_QUERY, '0, '0, '0, 1'b0);
      send_item(CMD_REPORT, '0, '0, '0, 1'b0);
      send_item(CMD_QUERY, '0, '0, '0, 1'b0);
   endtask

   // bursts of grants around a report, then one or two queries; some noise in between
   task automatic test_random_traffic(int n_items, int step_max, logic [TIME_W-1:0] start);
      int                target;
      logic [TIME_W-1:0] back;
      logic [TIME_W-1:0] rep_time;
      logic [OCC_W-1:0]  occ;
      cmd_type           cmd;
      now    = start;
      target = items_sent + n_items;
      while (items_sent < target) begin
         if ($urandom_range(99) < 10) begin
            cmd = cmd_type'($urandom_range(3));
            // a grant out of time order would pin the ring, keep grants in order
            send_item(cmd, (cmd == CMD_GRANT) ? now : rand48(), OCC_W'($urandom),
                      WORDS_W'($urandom), 1'($urandom_range(1)));
         end else begin
            repeat ($urandom_range(0, 6)) send_random_grant(step_max);
            back     = TIME_W'($urandom_range(0, 4 * step_max));
            rep_time = (now > back) ? now - back : '0;
            occ      = ($urandom_range(99) < 15) ? OCC_W'($urandom)
                                                 : OCC_W'($urandom_range(0, 3000));
            send_item(CMD_REPORT, rep_time, occ, WORDS_W'($urandom),
                      1'($urandom_range(1)));
            repeat ($urandom_range(0, 3)) send_random_grant(step_max);
            repeat ($urandom_range(1, 2))
               send_item(CMD_QUERY, rand48(), OCC_W'($urandom), WORDS_W'($urandom),
                         1'($urandom_range(1)));
         end
      end
   endtask

   // long receiver hold-off while queries keep coming
   task automatic test_output_stall();
      bit saved;
      saved         = quiet_mode;
      quiet_mode    = 1'b1;
      stall_request = 300;
      repeat (12) send_item(CMD_QUERY, rand48(), '0, '0, 1'b0);
      quiet_mode = saved;
   endtask

   initial begin
      errors            = 0;
      items_sent        = 0;
      grants_sent       = 0;
      reports_sent      = 0;
      estimates_checked = 0;
      trk_rtt           = '0;
      trk_slot          = '0;
      trk_window        = '0;
      trk_have_report   = 1'b0;
      trk_occ           = '0;
      trk_report_time   = '0;
      ring_head         = 0;
      ring_count        = 0;
      trk_overflow      = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_wr_en  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();

      set_config(32'd40, 32'd60, 48'd600);
      test_random_traffic(220, 40, 48'd1000);

      set_config('0, '0, '0);
      quiet_mode = 1'b1;
      test_random_traffic(200, 3, 48'd5000);
      quiet_mode = 1'b0;

      test_output_stall();

      set_config(RTT_W'($urandom_range(0, 300)), SLOT_W'($urandom_range(0, 600)),
                 TIME_W'($urandom_range(100, 800)));
      test_random_traffic(200, 40, rand48() >> 2);

      // all-ones: nothing is pruned, the ring fills and overflows
      set_config('1, '1, TIME_MAX);
      test_random_traffic(220, 2000, TIME_MAX - 48'd4000000);

      wait_idle();
      $display("Sent %0d items (%0d grants, %0d reports); %0d estimates checked.",
               items_sent, grants_sent, reports_sent, estimates_checked);
      $display("Swept zero, small, mid and all-ones registers; overflow flag ended at %0d.",
               trk_overflow);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
rtl/ghbe_pkg.sv
rtl/ghbe_ram.sv
rtl/ghbe_ctrl.sv
rtl/ghbe_dpath.sv
rtl/grant_history_backlog_estimator_unit.sv
tb/grant_history_backlog_estimator_unit_tb.sv
